FILE: sv/jtsm_pkg.sv
// Shared types and constants for the joint two-stack store with merge.
package jtsm_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // action codes
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_MERGE = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // one slot of the shared store
    typedef struct packed {
        logic              live;
        logic              owner;
        logic [DATA_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // store access from the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // pop result word
    typedef struct packed {
        logic              empty;
        logic [DATA_W-1:0] value;
    } t_res;

endpackage

FILE: sv/joint_two_stack_with_merge_top.sv
// Push, merge and clear complete as they are taken. A pop reads one slot a cycle, newest first;
// a hit is held in the controller result word, then in the output word register, and the
// input is freed once the output register takes it; a scan that finds nothing reports empty.
// A pop with no slot to read skips the scan and goes straight to its empty result word.
// Throughput: one item at a time; push/merge/clear one per cycle while no pop is busy, pops follow scan length.
// Reset (synchronous, active low) empties both stacks through the fill count; no clear pass.
module joint_two_stack_with_merge_top import jtsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic              i_stack_sel,
    input  logic [DATA_W-1:0] i_push_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_pop_value,
    output logic              o_was_empty
);

    t_mem_req           w_mem;
    logic [ENTRY_W-1:0] w_rdata;
    logic               w_res_valid;
    t_res               w_res;
    logic               w_res_ready;
    logic               r_out_valid;
    t_res               r_out;

    jtsm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (i_push_value),
        .o_mem        (w_mem),
        .i_rd_data    (w_rdata),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    jtsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // output word register
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_out.value;
    assign o_was_empty = r_out.empty;

endmodule

FILE: sv/jtsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jtsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/jtsm_ctrl.sv
// Action sequencer: push, pop scan, merge mark and clear over the shared store.
module jtsm_ctrl import jtsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic              i_stack_sel,
    input  logic [DATA_W-1:0] i_push_value,
    output t_mem_req          o_mem,
    input  t_entry            i_rd_data,
    output logic              o_res_valid,
    output t_res              o_res,
    input  logic              i_res_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;      // next slot to fill
    logic [CNT_W-1:0]  r_mcnt, n_mcnt;    // slots below this belong to the merge target
    logic              r_mtgt, n_mtgt;
    logic              r_sel, n_sel;
    logic [ADDR_W-1:0] r_addr, n_addr;    // next slot to read
    logic [ADDR_W-1:0] r_lo, n_lo;        // lowest slot worth reading
    logic              r_more, n_more;
    logic              r_pend, n_pend;    // read data this cycle belongs to r_paddr
    logic [ADDR_W-1:0] r_paddr, n_paddr;
    t_res              r_res, n_res;

    logic [CNT_W-1:0]  w_lo;
    logic              w_own;
    logic              w_hit;

    // scan floor: below the merge mark only the merge target owns slots
    assign w_lo  = (r_mtgt != i_stack_sel) ? r_mcnt : '0;
    assign w_own = ({1'b0, r_paddr} < r_mcnt) ? r_mtgt : i_rd_data.owner;
    assign w_hit = r_pend && i_rd_data.live && (w_own == r_sel);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mcnt  = r_mcnt;
        n_mtgt  = r_mtgt;
        n_sel   = r_sel;
        n_addr  = r_addr;
        n_lo    = r_lo;
        n_more  = r_more;
        n_pend  = 1'b0;
        n_paddr = r_addr;
        n_res   = r_res;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_cnt[ADDR_W-1:0];
        o_mem.wdata = '{live: 1'b1, owner: i_stack_sel, value: i_push_value};
        o_mem.raddr = r_addr;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sel = i_stack_sel;
                    case (i_action)
                        ACT_PUSH: begin
                            if (r_cnt < CNT_W'(DEPTH)) begin
                                o_mem.we = 1'b1;
                                n_cnt    = r_cnt + CNT_W'(1);
                            end
                        end
                        ACT_POP: begin
                            if (r_cnt > w_lo) begin
                                n_addr  = ADDR_W'(r_cnt - CNT_W'(1));
                                n_lo    = w_lo[ADDR_W-1:0];
                                n_more  = 1'b1;
                                n_state = S_SCAN;
                            end else begin
                                n_res   = '{empty: 1'b1, value: '0};
                                n_state = S_PUT;
                            end
                        end
                        ACT_MERGE: begin
                            n_mcnt = r_cnt;
                            n_mtgt = i_stack_sel;
                        end
                        ACT_CLEAR: begin
                            n_cnt  = '0;
                            n_mcnt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, check the one issued last cycle
                n_pend  = r_more;
                n_paddr = r_addr;
                if (r_more) begin
                    if (r_addr == r_lo) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_addr - ADDR_W'(1);
                    end
                end
                if (w_hit) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_paddr;
                    o_mem.wdata = '{live: 1'b0, owner: i_rd_data.owner,
                                    value: i_rd_data.value};
                    n_res   = '{empty: 1'b0, value: i_rd_data.value};
                    n_more  = 1'b0;
                    n_state = S_PUT;
                end else if (!r_pend && !r_more) begin
                    n_res   = '{empty: 1'b1, value: '0};
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mcnt  <= '0;
            r_mtgt  <= 1'b0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mcnt  <= n_mcnt;
            r_mtgt  <= n_mtgt;
            r_more  <= n_more;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_addr  <= n_addr;
        r_lo    <= n_lo;
        r_paddr <= n_paddr;
        r_res   <= n_res;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_res      = r_res;

    // a write never lands on the slot being read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && r_state == S_SCAN && r_more) |-> (o_mem.waddr != o_mem.raddr))
        else $error("store read and write hit the same slot");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("fill count beyond store depth");

    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= r_cnt)
        else $error("merge mark above fill count");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && !i_res_ready) |=> (r_state == S_PUT && $stable(r_res)))
        else $error("pending pop result lost");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the joint two-stack store with merge.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jtsm_pkg::*;

    localparam int RANDOM_WORDS = 620;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 10000000;

    // one input word plus its timing
    typedef struct {
        logic [1:0]        action;
        logic              sel;
        logic [DATA_W-1:0] value;
        int                gap;
        bit                wait_drain;
        bit                hold_out;
    } t_stack_op;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_action     = ACT_PUSH;
    logic              i_stack_sel  = 1'b0;
    logic [DATA_W-1:0] i_push_value = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [DATA_W-1:0] o_pop_value;
    logic              o_was_empty;

    joint_two_stack_with_merge_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pop_value  (o_pop_value),
        .o_was_empty  (o_was_empty)
    );

    // shadow copy of the shared store
    logic [DATA_W-1:0] slot_value [DEPTH];
    logic              slot_owner [DEPTH];
    bit                slot_live  [DEPTH];
    int                fill_count;

    t_stack_op op_queue [$];
    t_res      pop_expect [$];

    int total_words    = 0;
    int words_taken    = 0;
    int pops_sent      = 0;
    int results_seen   = 0;
    int hold_reqs      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_burst       = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // zero-wait runs now and then, otherwise a uniformly drawn wait
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            burst = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // apply one word to the shadow store; a pop yields one result
    function automatic void apply_to_stacks(input t_stack_op w, output bit gives,
                                            output t_res res);
        int slot;
        gives = 1'b0;
        res   = '0;
        case (w.action)
            ACT_PUSH: begin
                if (fill_count < DEPTH) begin
                    slot_value[fill_count] = w.value;
                    slot_owner[fill_count] = w.sel;
                    slot_live[fill_count]  = 1'b1;
                    fill_count++;
                end
            end
            ACT_POP: begin
                gives     = 1'b1;
                res.empty = 1'b1;
                // newest live slot owned by the selected stack
                for (slot = fill_count - 1; slot >= 0 && res.empty; slot--) begin
                    if (slot_live[slot] && slot_owner[slot] == w.sel) begin
                        res.empty       = 1'b0;
                        res.value       = slot_value[slot];
                        slot_live[slot] = 1'b0;
                    end
                end
            end
            ACT_MERGE: begin
                for (slot = 0; slot < DEPTH; slot++) begin
                    if (slot_live[slot])
                        slot_owner[slot] = w.sel;
                end
            end
            ACT_CLEAR: begin
                for (slot = 0; slot < DEPTH; slot++)
                    slot_live[slot] = 1'b0;
                fill_count = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string what, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        if (mismatch_count < 10)
            $display("pop result %0d: %s expected %h got %h", results_seen, what, want, got);
        mismatch_count++;
    endfunction

    // gap < 0 means draw one
    task automatic add_word(input logic [1:0] act, input logic sel,
                            input logic [DATA_W-1:0] value, input bit drain,
                            input bit hold, input int gap);
        t_stack_op w;
        w.action     = act;
        w.sel        = sel;
        w.value      = value;
        w.gap        = (gap < 0) ? draw_wait(tx_burst) : gap;
        w.wait_drain = drain || ($urandom_range(0, 149) == 0);
        w.hold_out   = hold;
        op_queue.push_back(w);
        total_words++;
    endtask

    // a few pushes, then pops offered back to back while the receiver holds off
    task automatic hold_burst();
        repeat (6) add_word(ACT_PUSH, 1'($urandom_range(0, 1)), pick_value(), 0, 0, -1);
        add_word(ACT_POP, 1'($urandom_range(0, 1)), $urandom, 0, 1, 0);
        repeat (10) add_word(ACT_POP, 1'($urandom_range(0, 1)), $urandom, 0, 0, 0);
    endtask

    // sender: offers words from the queue, predicts each accepted one
    t_stack_op cur_word;
    bit        have_word = 1'b0;
    int        gap_left  = 0;

    always @(posedge i_clk) begin : drive_words
        bit   took;
        bit   gives;
        bit   drained;
        bit   nxt_valid;
        t_res res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took  = i_in_valid && !o_in_stall;
            gives = 1'b0;
            if (took) begin
                apply_to_stacks(cur_word, gives, res);
                if (gives) begin
                    pop_expect.push_back(res);
                    pops_sent <= pops_sent + 1;
                end
                if (cur_word.hold_out)
                    hold_reqs <= hold_reqs + 1;
                words_taken <= words_taken + 1;
                have_word = 1'b0;
            end
            // a stalled word stays on the bus unchanged
            if (!(i_in_valid && !took)) begin
                if (!have_word && op_queue.size() > 0) begin
                    cur_word  = op_queue.pop_front();
                    have_word = 1'b1;
                    gap_left  = cur_word.gap;
                end
                nxt_valid = 1'b0;
                if (have_word) begin
                    drained = (pops_sent + int'(gives)) == results_seen;
                    if (cur_word.wait_drain && drained)
                        cur_word.wait_drain = 1'b0;
                    if (!cur_word.wait_drain) begin
                        if (gap_left == 0)
                            nxt_valid = 1'b1;
                        else
                            gap_left--;
                    end
                end
                i_in_valid <= nxt_valid;
                if (nxt_valid) begin
                    i_action     <= cur_word.action;
                    i_stack_sel  <= cur_word.sel;
                    i_push_value <= cur_word.value;
                end
            end
        end
    end

    // receiver: random stalls, long hold on request, checks each pop word
    int rx_wait   = 0;
    int rx_burst  = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin : check_results
        t_res want;
        int   wait_next;
        int   hold_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pops_sent == results_seen) begin
                    note_mismatch("unexpected word", '0, o_pop_value);
                end else begin
                    want = pop_expect.pop_front();
                    if (o_pop_value !== want.value)
                        note_mismatch("pop_value", want.value, o_pop_value);
                    if (o_was_empty !== want.empty)
                        note_mismatch("was_empty", DATA_W'(want.empty), DATA_W'(o_was_empty));
                end
                results_seen <= results_seen + 1;
                wait_next = draw_wait(rx_burst);
            end else begin
                wait_next = (rx_wait > 0) ? rx_wait - 1 : 0;
            end
            if (hold_seen != hold_reqs) begin
                hold_next = LONG_HOLD;
                hold_seen <= hold_reqs;
            end else begin
                hold_next = (hold_left > 0) ? hold_left - 1 : 0;
            end
            rx_wait     <= wait_next;
            hold_left   <= hold_next;
            i_out_stall <= (wait_next > 0) || (hold_next > 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int random_start;
        int pick;
        int len;
        int kind;
        logic [1:0] act;

        for (int k = 0; k < DEPTH; k++)
            slot_live[k] = 1'b0;
        fill_count = 0;

        // directed: empty pops, extreme values, merges both ways, clear
        add_word(ACT_POP,   1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_POP,   1'b1, 32'hFFFF_FFFF, 0, 0, -1);
        add_word(ACT_PUSH,  1'b0, 32'h7FFF_FFFF, 0, 0, -1);
        add_word(ACT_PUSH,  1'b1, 32'h8000_0000, 0, 0, -1);
        add_word(ACT_PUSH,  1'b0, 32'h0000_0000, 0, 0, -1);
        add_word(ACT_PUSH,  1'b1, 32'hFFFF_FFFF, 0, 0, -1);
        add_word(ACT_MERGE, 1'b1, 32'h1234_5678, 0, 0, -1);
        add_word(ACT_POP,   1'b1, 32'h0,         0, 0, -1);
        add_word(ACT_POP,   1'b1, 32'h0,         0, 0, -1);
        add_word(ACT_POP,   1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_MERGE, 1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_MERGE, 1'b0, 32'hFFFF_FFFF, 0, 0, -1);
        add_word(ACT_POP,   1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_PUSH,  1'b1, 32'h5555_5555, 0, 0, -1);
        add_word(ACT_POP,   1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_POP,   1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_POP,   1'b1, 32'h0,         0, 0, -1);
        add_word(ACT_PUSH,  1'b0, 32'hAAAA_AAAA, 0, 0, -1);
        add_word(ACT_CLEAR, 1'b1, 32'hDEAD_BEEF, 0, 0, -1);
        add_word(ACT_POP,   1'b0, 32'h0,         0, 0, -1);
        add_word(ACT_PUSH,  1'b1, 32'h0000_0001, 0, 0, -1);
        add_word(ACT_POP,   1'b1, 32'h0,         0, 0, -1);

        // fill the store past full: extra pushes dropped, freed slots not reused
        add_word(ACT_CLEAR, 1'b0, $urandom, 1, 0, -1);
        repeat (DEPTH + 6)
            add_word(ACT_PUSH, 1'($urandom_range(0, 1)), pick_value(), 0, 0, -1);
        repeat (4) add_word(ACT_POP, 1'($urandom_range(0, 1)), $urandom, 0, 0, -1);
        add_word(ACT_PUSH, 1'b0, pick_value(), 0, 0, -1);
        add_word(ACT_MERGE, 1'b0, $urandom, 0, 0, -1);
        repeat (3) add_word(ACT_POP, 1'b0, $urandom, 0, 0, -1);
        add_word(ACT_POP, 1'b1, $urandom, 0, 0, -1);
        add_word(ACT_CLEAR, 1'b1, $urandom, 0, 0, -1);
        add_word(ACT_PUSH, 1'b1, pick_value(), 0, 0, -1);
        add_word(ACT_POP, 1'b1, $urandom, 0, 0, -1);
        hold_burst();

        // random: mostly short push/pop/merge runs between clears
        random_start = total_words;
        add_word(ACT_PUSH, 1'b0, pick_value(), 1, 0, -1);
        while (total_words - random_start < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                if ($urandom_range(0, 1))
                    add_word(ACT_CLEAR, 1'($urandom_range(0, 1)), $urandom, 0, 0, -1);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 150)
                                                   : $urandom_range(1, 40);
                repeat (len) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 50)
                        act = ACT_PUSH;
                    else if (kind < 85)
                        act = ACT_POP;
                    else
                        act = ACT_MERGE;
                    add_word(act, 1'($urandom_range(0, 1)), pick_value(), 0, 0, -1);
                end
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 8))
                    add_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                             0, 0, -1);
            end else begin
                hold_burst();
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken != total_words || pops_sent != results_seen)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && pop_expect.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: joint_two_stack_with_merge_top.f
sv/jtsm_pkg.sv
sv/jtsm_ram.sv
sv/jtsm_ctrl.sv
sv/joint_two_stack_with_merge_top.sv
tb/sv/testbench.sv
